// ===== rtl/kufc_pkg.sv =====
// ----------------------------------------------------------------------------
// kufc_pkg: shared types and constants for the union-find cost block
// Table geometry, item codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package kufc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NODE_W    = 10;
  localparam int CFG_W     = 11;
  localparam int WGT_W     = 32;
  localparam int COST_W    = 48;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = CFG_W'(1024);
  localparam logic [COST_W-1:0] COST_MAX       = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_JOIN  = 2'd1,
    FN_EDGE  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SWEEP,
    OP_START,
    OP_WALK,
    OP_CMP,
    OP_LINK,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   side_b;  // walk from node_b rather than node_a
    logic   all;     // sweep the whole table
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_link;
    logic sweep_empty;
    logic sweep_last;
    logic root_hit;
    logic cmp_done;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] node_to_idx(input logic [NODE_W-1:0] node);
    return IDX_W'(node);
  endfunction

endpackage

// ===== rtl/kruskal_union_find_cost_top.sv =====
// ----------------------------------------------------------------------------
// kruskal_union_find_cost_top: Kruskal spanning tree cost with union-find
// Channel  | signals                                   | dir | beat
// ---------+-------------------------------------------+-----+-----------------
// in       | in_valid_i, in_stall_o, func_i, node_a_i, | in  | valid & !stall
//          | node_b_i, edge_weight_i, last_edge_i      |     |
// out      | out_valid_o, out_stall_i, merged_o,       | out | valid & !stall
//          | total_cost_o, final_res_o                 |     |
// cfg      | cfg_valid_i, cfg_ready_o, cfg_node_count_i| in  | valid & ready
//
// One item at a time. A join or edge walks from node_a to its root and then
// compresses that path, then does the same from node_b, and links the roots;
// the single read port of the parent table reads one link per cycle in the
// walk and one per cycle in the compress pass. A clear writes identity into
// the first min(node_count, 1024) entries, one table entry written per cycle.
// After reset a sweep loads all 1024 entries with identity before the first
// beat is taken; cfg writes are taken any time.
// The result register frees the output side: a stalled result holds while the
// next item is already being worked on, up to its own emit.
// ----------------------------------------------------------------------------
module kruskal_union_find_cost_top import kufc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WGT_W-1:0]    edge_weight_i,
  input  logic                last_edge_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                merged_o,
  output logic [COST_W-1:0]   total_cost_o,
  output logic                final_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_node_count_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Node count must be written only while idle; the block does not enforce it. Always take the beat.
  assign cfg_ready_o = 1'b1;

  kufc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Parent table, walk pointers, saturating cost and result register
  kufc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_node_count_i),
    .func_i        (func_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_weight_i (edge_weight_i),
    .last_edge_i   (last_edge_i),
    .merged_o      (merged_o),
    .total_cost_o  (total_cost_o),
    .final_res_o   (final_res_o)
  );

endmodule

// ===== rtl/kufc_dp.sv =====
// ----------------------------------------------------------------------------
// kufc_dp: datapath of the union-find cost block
// Parent table memory, walk pointers, running cost and the result register.
// ----------------------------------------------------------------------------
module kufc_dp import kufc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]          func_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WGT_W-1:0]    edge_weight_i,
  input  logic                last_edge_i,
  output logic                merged_o,
  output logic [COST_W-1:0]   total_cost_o,
  output logic                final_res_o
);

  logic [IDX_W-1:0]  mem [MAX_NODES];
  logic [IDX_W-1:0]  rd_data_q;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  wdata;

  logic [CFG_W-1:0]  node_count_q;
  logic [CNT_W-1:0]  sw_q;
  logic [CNT_W-1:0]  sw_lim;
  logic [1:0]        func_q;
  logic              rng_ok_q;
  logic [IDX_W-1:0]  a_q, b_q;
  logic [WGT_W-1:0]  w_q;
  logic              last_q;
  logic [IDX_W-1:0]  ptr_q, root_q, ra_q;
  logic              merged_q;
  logic [COST_W-1:0] cost_q;
  logic [COST_W:0]   cost_sum;
  logic [IDX_W-1:0]  start;

  assign start  = cmd_i.side_b ? b_q : a_q;
  assign sw_lim = cmd_i.all ? CNT_W'(MAX_NODES) :
                  (32'(node_count_q) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                  CNT_W'(node_count_q);
  assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(w_q);

  assign stat_o.is_clear    = (func_q == FN_CLEAR);
  assign stat_o.is_link     = rng_ok_q && (func_q == FN_JOIN || func_q == FN_EDGE);
  assign stat_o.sweep_empty = (node_count_q == '0);
  assign stat_o.sweep_last  = ((sw_q + CNT_W'(1)) == sw_lim);
  assign stat_o.root_hit    = (rd_data_q == ptr_q);
  assign stat_o.cmp_done    = (rd_data_q == root_q);

  // Memory port steering
  always_comb begin
    raddr = ptr_q;
    we    = 1'b0;
    waddr = ptr_q;
    wdata = root_q;
    case (cmd_i.op)
      OP_SWEEP: begin
        we    = 1'b1;
        waddr = sw_q[IDX_W-1:0];
        wdata = sw_q[IDX_W-1:0];
      end
      OP_START: raddr = start;
      OP_WALK:  raddr = stat_o.root_hit ? start : rd_data_q;
      OP_CMP: begin
        raddr = rd_data_q;
        we    = !stat_o.cmp_done;
      end
      OP_LINK: begin
        we    = (ra_q != root_q);
        waddr = ra_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      sw_q         <= '0;
      cost_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_SWEEP) begin
        sw_q <= stat_o.sweep_last ? '0 : sw_q + CNT_W'(1);
      end
      if (cmd_i.op == OP_LOAD && func_i == FN_CLEAR) begin
        cost_q <= '0;
      end
      if (cmd_i.op == OP_LINK && ra_q != root_q && func_q == FN_EDGE) begin
        cost_q <= (cost_sum > (COST_W + 1)'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q   <= func_i;
        rng_ok_q <= (32'(node_a_i) < 32'(MAX_NODES)) && (32'(node_b_i) < 32'(MAX_NODES));
        a_q      <= node_to_idx(node_a_i);
        b_q      <= node_to_idx(node_b_i);
        w_q      <= edge_weight_i;
        last_q   <= last_edge_i;
        merged_q <= 1'b0;
      end
      OP_START: ptr_q <= start;
      OP_WALK: begin
        if (stat_o.root_hit) begin
          root_q <= ptr_q;
          ptr_q  <= start;
        end else begin
          ptr_q  <= rd_data_q;
        end
      end
      OP_CMP: begin
        ptr_q <= rd_data_q;
        if (stat_o.cmp_done && !cmd_i.side_b) begin
          ra_q <= root_q;
        end
      end
      OP_LINK: merged_q <= (ra_q != root_q);
      OP_EMIT: begin
        merged_o     <= merged_q;
        total_cost_o <= cost_q;
        final_res_o  <= last_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/kufc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kufc_ctrl: sequencer of the union-find cost block
// Steps one item through sweep, find/compress of both ends, link and emit.
// ----------------------------------------------------------------------------
module kufc_ctrl import kufc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_START_A,
    ST_WALK_A,
    ST_CMP_A,
    ST_START_B,
    ST_WALK_B,
    ST_CMP_B,
    ST_LINK,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op     = OP_IDLE;
    cmd_o.side_b = 1'b0;
    cmd_o.all    = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.op  = OP_SWEEP;
        cmd_o.all = 1'b1;
      end
      ST_IDLE:    cmd_o.op = in_valid_i ? OP_LOAD : OP_IDLE;
      ST_CLEAR:   cmd_o.op = OP_SWEEP;
      ST_START_A: cmd_o.op = OP_START;
      ST_WALK_A:  cmd_o.op = OP_WALK;
      ST_CMP_A:   cmd_o.op = OP_CMP;
      ST_START_B: begin
        cmd_o.op     = OP_START;
        cmd_o.side_b = 1'b1;
      end
      ST_WALK_B: begin
        cmd_o.op     = OP_WALK;
        cmd_o.side_b = 1'b1;
      end
      ST_CMP_B: begin
        cmd_o.op     = OP_CMP;
        cmd_o.side_b = 1'b1;
      end
      ST_LINK:    cmd_o.op = OP_LINK;
      ST_RESP:    cmd_o.op = out_free ? OP_EMIT : OP_IDLE;
      default:    cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT:     if (stat_i.sweep_last) state_q <= ST_IDLE;
        ST_IDLE:     if (in_valid_i) state_q <= ST_DISPATCH;
        ST_DISPATCH: begin
          if (stat_i.is_clear) begin
            state_q <= stat_i.sweep_empty ? ST_RESP : ST_CLEAR;
          end else if (stat_i.is_link) begin
            state_q <= ST_START_A;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_CLEAR:    if (stat_i.sweep_last) state_q <= ST_RESP;
        ST_START_A:  state_q <= ST_WALK_A;
        ST_WALK_A:   if (stat_i.root_hit) state_q <= ST_CMP_A;
        ST_CMP_A:    if (stat_i.cmp_done) state_q <= ST_START_B;
        ST_START_B:  state_q <= ST_WALK_B;
        ST_WALK_B:   if (stat_i.root_hit) state_q <= ST_CMP_B;
        ST_CMP_B:    if (stat_i.cmp_done) state_q <= ST_LINK;
        ST_LINK:     state_q <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Kruskal union-find cost block
// Streams clear, join and weighted-edge items through the block and compares
// every result beat with a cycle-free model of the parent table, its path
// compression and the running spanning-tree cost, across node count settings.
// ----------------------------------------------------------------------------
module tb_top;
  import kufc_pkg::*;

  typedef struct packed {
    func_e              func;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [WGT_W-1:0]   weight;
    logic               last;
  } edge_item_t;

  typedef struct packed {
    logic               merged;
    logic [COST_W-1:0]  cost;
    logic               last;
  } tree_result_t;

  // Drive every input to a known value from time zero.
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i           = FN_CLEAR;
  logic [NODE_W-1:0]  node_a_i         = '0;
  logic [NODE_W-1:0]  node_b_i         = '0;
  logic [WGT_W-1:0]   edge_weight_i    = '0;
  logic               last_edge_i      = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic               merged_o;
  logic [COST_W-1:0]  total_cost_o;
  logic               final_res_o;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_node_count_i = NODE_COUNT_RST;

  kruskal_union_find_cost_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .edge_weight_i    (edge_weight_i),
    .last_edge_i      (last_edge_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .merged_o         (merged_o),
    .total_cost_o     (total_cost_o),
    .final_res_o      (final_res_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_node_count_i (cfg_node_count_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Forest model: the bench's own copy of the parent table, the running cost
  // and the node count register.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]   forest_parent [MAX_NODES];
  logic [COST_W-1:0]  tree_cost;
  logic [CFG_W-1:0]   clear_span;

  // Walk to the root, then point every node on the walked path straight at it.
  // The step bound only guards against a corrupt table; links always join two
  // roots, so no cycle can form.
  function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] start);
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] nxt;
    int               steps;
    r = start;
    steps = 0;
    while (forest_parent[r] != r && steps < MAX_NODES) begin
      r = forest_parent[r];
      steps++;
    end
    x = start;
    steps = 0;
    while (forest_parent[x] != r && steps < MAX_NODES) begin
      nxt = forest_parent[x];
      forest_parent[x] = r;
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  // Advance the forest by one item and return the result beat it must produce.
  // Nodes are 10 bits wide and the table holds 1024 entries, so every node
  // named by an item lies inside the table.
  function automatic tree_result_t apply_item(input edge_item_t it);
    tree_result_t     res;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [COST_W:0]  sum;
    int               lim;
    int               i;
    res.merged = 1'b0;
    case (it.func)
      FN_CLEAR: begin
        // Entries at and above the node count keep whatever they held.
        lim = (clear_span > MAX_NODES) ? MAX_NODES : int'(clear_span);
        for (i = 0; i < lim; i++) forest_parent[i] = IDX_W'(i);
        tree_cost = '0;
      end
      FN_JOIN, FN_EDGE: begin
        ra = find_root(IDX_W'(it.node_a));
        rb = find_root(IDX_W'(it.node_b));
        if (ra != rb) begin
          forest_parent[ra] = rb;
          res.merged = 1'b1;
          if (it.func == FN_EDGE) begin
            // Saturate on carry out. With 1024 nodes at most 1023 weights can
            // add up between clears, so the ceiling is out of reach here.
            sum = {1'b0, tree_cost} + COST_W'(it.weight);
            tree_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
          end
        end
      end
      default: ;  // unused selector: no change
    endcase
    res.cost = tree_cost;
    res.last = it.last;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, knobs and the mismatch counter
  // --------------------------------------------------------------------------
  edge_item_t   pending_edges[$];      // items waiting to be offered
  tree_result_t predicted_results[$];  // result beats owed by the block
  edge_item_t   offered;               // payload currently on the input port
  int unsigned  in_idle_pct  = 33;
  int unsigned  out_idle_pct = 33;
  int           beats_in     = 0;
  int           beats_out    = 0;
  int           mismatch_count = 0;
  logic         hold_req     = 1'b0;
  logic         hold_off     = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: predict on each accepted beat, then refill the port when it
  // is free. Hold the payload steady while the block stalls it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      func_i        <= FN_CLEAR;
      node_a_i      <= '0;
      node_b_i      <= '0;
      edge_weight_i <= '0;
      last_edge_i   <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_results.push_back(apply_item(offered));
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        // Decide whether to offer before looking at anything the block drives.
        if (pending_edges.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          offered = pending_edges.pop_front();
          func_i        <= offered.func;
          node_a_i      <= offered.node_a;
          node_b_i      <= offered.node_b;
          edge_weight_i <= offered.weight;
          last_edge_i   <= offered.last;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each accepted result beat field by field against the
  // oldest prediction, and stall at random or during the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    tree_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing predicted", beats_out));
        end else begin
          want = predicted_results.pop_front();
          if (merged_o !== want.merged)
            report_mismatch($sformatf("beat %0d merged got %b want %b",
                                      beats_out, merged_o, want.merged));
          if (total_cost_o !== want.cost)
            report_mismatch($sformatf("beat %0d total_cost got %0h want %0h",
                                      beats_out, total_cost_o, want.cost));
          if (final_res_o !== want.last)
            report_mismatch($sformatf("beat %0d final_res got %b want %b",
                                      beats_out, final_res_o, want.last));
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < out_idle_pct);
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the block parks one
  // result, finishes the next item and then has to stall its input.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_item(input func_e fn, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [WGT_W-1:0] w,
                           input logic last);
    edge_item_t it;
    it.func   = fn;
    it.node_a = a;
    it.node_b = b;
    it.weight = w;
    it.last   = last;
    pending_edges.push_back(it);
  endtask

  // Wait until every queued item is taken and every owed result has arrived;
  // each item yields exactly one result, so the block is idle afterwards.
  task automatic drain();
    while (pending_edges.size() != 0 || in_valid_i || predicted_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_node_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    clear_span = value;
  endtask

  initial begin
    int               phase;
    int               len;
    int               win;
    int               base;
    int               roll;
    int               i;
    int               items_done;
    logic [CFG_W-1:0] nc;
    logic [WGT_W-1:0] w;
    logic [WGT_W:0]   wsum;
    logic             noise_last;

    for (i = 0; i < MAX_NODES; i++) forest_parent[i] = IDX_W'(i);
    tree_cost  = '0;
    clear_span = NODE_COUNT_RST;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, on the reset table and reset node count. The block runs
    // its identity sweep first, so these beats wait on the stall.
    push_item(FN_EDGE, 10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0);   // merge at full weight
    push_item(FN_EDGE, 10'd1023, 10'd0, 32'h0000_0001, 1'b0);   // same set, no cost
    push_item(FN_JOIN, 10'd5, 10'd6, 32'hFFFF_FFFF, 1'b0);      // free merge
    push_item(FN_EDGE, 10'd6, 10'd5, 32'h0000_0000, 1'b0);      // same set via join
    push_item(FN_EDGE, 10'd7, 10'd7, 32'h8000_0000, 1'b0);      // node with itself
    push_item(FN_NONE, 10'h3FF, 10'h2AA, 32'hFFFF_FFFF, 1'b1);  // unused selector
    push_item(FN_EDGE, 10'd5, 10'd1023, 32'h0000_0000, 1'b0);   // merge two sets, zero weight
    // Build a ten-deep chain, then walk and compress it.
    for (i = 20; i < 30; i++)
      push_item(FN_JOIN, NODE_W'(i), NODE_W'(i + 1), 32'h5555_5555, 1'b0);
    push_item(FN_EDGE, 10'd20, 10'd40, 32'h1234_5678, 1'b0);
    push_item(FN_EDGE, 10'd25, 10'd40, 32'h0000_0003, 1'b0);    // same set after compress
    push_item(FN_CLEAR, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 1'b1); // clear, marked final
    push_item(FN_EDGE, 10'd0, 10'd1023, 32'h0000_0001, 1'b1);   // first edge after clear
    push_item(FN_NONE, 10'd0, 10'd0, 32'h0000_0000, 1'b0);
    drain();

    // Random part: one node count setting per phase, then mostly a clear and a
    // weight-sorted edge stream over a small window of nodes, with noise mixed in.
    items_done = 0;
    for (phase = 0; items_done < 1500; phase++) begin
      drain();
      case (phase)
        0:       nc = CFG_W'(1);
        1:       nc = CFG_W'(0);     // clear touches no entry
        2:       nc = '1;            // far past the table
        3:       nc = CFG_W'(1024);
        4:       nc = CFG_W'(1025);
        5:       nc = CFG_W'(2);
        default: nc = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1, 1024))
                                               : CFG_W'($urandom_range(2, 48));
      endcase
      write_node_count(nc);

      // Two back-to-back phases run with no idling on either side.
      in_idle_pct  = (phase == 6 || phase == 7) ? 0 : 33;
      out_idle_pct = in_idle_pct;
      @(negedge clk_i);

      len  = (in_idle_pct == 0) ? 150 : $urandom_range(10, 70);
      win  = $urandom_range(2, 40);
      if (nc >= 2 && nc < win) win = int'(nc);
      base = ($urandom_range(3) == 0) ? $urandom_range(0, MAX_NODES - win) : 0;
      w    = ($urandom_range(1) == 0) ? WGT_W'($urandom_range(0, 255)) : WGT_W'($urandom());

      // Leave out the opening clear now and then: a stream over a stale forest.
      if ($urandom_range(7) != 0) begin
        push_item(FN_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()), $urandom(), 1'b0);
        items_done++;
      end
      for (i = 0; i < len; i++) begin
        roll = $urandom_range(99);
        noise_last = (i == len - 1) ? 1'b1 : 1'(($urandom_range(15) == 0));
        if (roll < 80) begin
          push_item(FN_EDGE, NODE_W'(base + $urandom_range(0, win - 1)),
                    NODE_W'(base + $urandom_range(0, win - 1)), w, 1'(i == len - 1));
          wsum = {1'b0, w} + (WGT_W + 1)'($urandom_range(0, 1 << $urandom_range(0, 20)));
          w = wsum[WGT_W] ? '1 : wsum[WGT_W-1:0];
        end else if (roll < 88) begin
          push_item(FN_JOIN, NODE_W'(base + $urandom_range(0, win - 1)),
                    NODE_W'(base + $urandom_range(0, win - 1)), $urandom(), noise_last);
        end else if (roll < 93) begin
          push_item(FN_EDGE, NODE_W'($urandom()), NODE_W'($urandom()), $urandom(),
                    noise_last);
        end else if (roll < 97) begin
          push_item(FN_NONE, NODE_W'($urandom()), NODE_W'($urandom()), $urandom(),
                    noise_last);
          items_done--;  // ignored by the block; does not count
        end else begin
          push_item(FN_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()), $urandom(),
                    noise_last);
        end
        items_done++;
      end
      if (phase == 8) hold_req = 1'b1;
    end

    // Let the result register settle; a stray extra beat would show up here.
    drain();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog. Slowest legal run: ~1600 items, each at a worst-case walk,
  // plus stalls, the hold-off and the post-reset sweep, taken several times over.
  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
